// ----- rtl/sbus_frame_receiver_decoder_unit_defines.svh -----
// assertion macros for the sbus frame receiver decoder unit
`ifndef SBUS_FRAME_RECEIVER_DECODER_UNIT_DEFINES_SVH
`define SBUS_FRAME_RECEIVER_DECODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define SFRD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sfrd assertion failed");
// condition in one cycle implies a condition in the next
`define SFRD_ASSERT_NEXT(label, cond, expct) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expct)) \
		else $error("sfrd sequence assertion failed");
`else
`define SFRD_ASSERT(label, prop)
`define SFRD_ASSERT_NEXT(label, cond, expct)
`endif

`endif

// ----- rtl/sfrd_pkg.sv -----
// shared types and constants of the sbus frame receiver decoder
package sfrd_pkg;

	localparam int FRAME_BYTES   = 25;
	localparam int PAYLOAD_BYTES = 22;
	localparam int BYTE_W        = 8;
	localparam int CH_W          = 11;
	localparam int PROP_CHANNELS = 16;
	localparam int POS_W         = 5;
	localparam int IDX_W         = 5;
	localparam int PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
	// stored bytes: payload bytes plus the flag byte, start byte not kept
	localparam int STORE_W       = (FRAME_BYTES - 2) * BYTE_W;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] FIRST_POS = POS_W'(1);

	localparam logic [IDX_W-1:0] CH_DIG0 = IDX_W'(PROP_CHANNELS);
	localparam logic [IDX_W-1:0] CH_DIG1 = IDX_W'(PROP_CHANNELS + 1);

	localparam logic [CH_W-1:0] CH_MASK = 11'h7FF;

	localparam int FLAG_DIG0_BIT = 0;
	localparam int FLAG_DIG1_BIT = 1;
	localparam int FLAG_LOST_BIT = 2;
	localparam int FLAG_FS_BIT   = 3;

	localparam int FQ_DEPTH = 2;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_START_BYTE    = 2'd0,
		REG_END_BYTE      = 2'd1,
		REG_ALT_END_MASK  = 2'd2,
		REG_ALT_END_VALUE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] end_byte;
		logic [BYTE_W-1:0] alt_end_mask;
		logic [BYTE_W-1:0] alt_end_value;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    flags;
		logic [PAYLOAD_W-1:0] payload;
	} frame_t;

endpackage

// ----- rtl/sfrd_regs.sv -----
// configuration registers behind the apb-style port
module sfrd_regs
	import sfrd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte    <= 8'h0F;
			cfg_q.end_byte      <= 8'h00;
			cfg_q.alt_end_mask  <= 8'h0F;
			cfg_q.alt_end_value <= 8'h04;
		end else if (wr_en) begin
			unique case (idx)
				REG_START_BYTE:    cfg_q.start_byte    <= pwdata[BYTE_W-1:0];
				REG_END_BYTE:      cfg_q.end_byte      <= pwdata[BYTE_W-1:0];
				REG_ALT_END_MASK:  cfg_q.alt_end_mask  <= pwdata[BYTE_W-1:0];
				REG_ALT_END_VALUE: cfg_q.alt_end_value <= pwdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_START_BYTE:    prdata[BYTE_W-1:0] = cfg_q.start_byte;
			REG_END_BYTE:      prdata[BYTE_W-1:0] = cfg_q.end_byte;
			REG_ALT_END_MASK:  prdata[BYTE_W-1:0] = cfg_q.alt_end_mask;
			REG_ALT_END_VALUE: prdata[BYTE_W-1:0] = cfg_q.alt_end_value;
			default:           prdata = '0;
		endcase
	end

endmodule

// ----- rtl/sfrd_front.sv -----
// byte front end: start search, frame assembly and end byte check
module sfrd_front
	import sfrd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              push,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              full,
	input  logic              fq_full,
	output logic              fq_push,
	output frame_t            fq_data
);

	logic               in_frame_q;
	logic [POS_W-1:0]   pos_q;
	logic [STORE_W-1:0] store_q;
	logic               accept;
	logic               at_last;
	logic               end_ok;

	assign at_last = in_frame_q && (pos_q == LAST_POS);
	// hold off the closing byte only while there is no room for the frame
	assign full    = at_last && fq_full;
	assign accept  = push && !full;
	assign end_ok  = (rx_byte == cfg.end_byte) ||
	                 ((rx_byte & cfg.alt_end_mask) == cfg.alt_end_value);

	assign fq_push = accept && at_last && end_ok;
	assign fq_data = frame_t'(store_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
		end else if (accept) begin
			if (!in_frame_q) begin
				if (rx_byte == cfg.start_byte) begin
					in_frame_q <= 1'b1;
					pos_q      <= FIRST_POS;
				end
			end else if (at_last) begin
				in_frame_q <= 1'b0;
				pos_q      <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// bytes enter at the top so byte 1 ends up in the lowest lane
	always_ff @(posedge clk) begin
		if (accept && in_frame_q && !at_last) begin
			store_q <= {rx_byte, store_q[STORE_W-1:BYTE_W]};
		end
	end

endmodule

// ----- rtl/sfrd_frame_q.sv -----
// short queue of checked frames between front and back
module sfrd_frame_q
	import sfrd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   valid,
	output frame_t pop_data
);

	frame_t              mem_q [FQ_DEPTH];
	logic [FQ_PTR_W-1:0] wr_ptr_q;
	logic [FQ_PTR_W-1:0] rd_ptr_q;
	logic [FQ_CNT_W-1:0] cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full     = (cnt_q == FQ_CNT_W'(FQ_DEPTH));
	assign valid    = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 :
				            wr_ptr_q + FQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 :
				            rd_ptr_q + FQ_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + FQ_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - FQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/sfrd_back.sv -----
// channel unpacker: one result a cycle into the output register while a stalled pop does not hold it
module sfrd_back
	import sfrd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fq_valid,
	input  frame_t           fq_data,
	output logic             fq_pop,
	input  logic             pop,
	output logic             empty,
	output logic [IDX_W-1:0] channel_index,
	output logic [CH_W-1:0]  channel_value,
	output logic             frame_lost,
	output logic             failsafe,
	output logic             last
);

	logic                 busy_q;
	logic [IDX_W-1:0]     chan_q;
	logic [PAYLOAD_W-1:0] work_q;
	logic [BYTE_W-1:0]    flags_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     index_q;
	logic [CH_W-1:0]      value_q;
	logic                 lost_q;
	logic                 fs_q;
	logic                 last_q;
	logic                 emit;
	logic                 load;
	logic                 chan_last;
	logic [CH_W-1:0]      value_next;

	assign chan_last = (chan_q == CH_DIG1);
	assign emit      = busy_q && (!out_valid_q || pop);
	assign load      = fq_valid && (!busy_q || (emit && chan_last));
	assign fq_pop    = load;

	always_comb begin
		if (chan_q < IDX_W'(PROP_CHANNELS)) begin
			value_next = work_q[CH_W-1:0];
		end else if (chan_q == CH_DIG0) begin
			value_next = flags_q[FLAG_DIG0_BIT] ? CH_MASK : '0;
		end else begin
			value_next = flags_q[FLAG_DIG1_BIT] ? CH_MASK : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			chan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				chan_q <= '0;
			end else if (emit) begin
				if (chan_last) begin
					busy_q <= 1'b0;
				end else begin
					chan_q <= chan_q + IDX_W'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// channels sit back to back, so a shift by one channel width exposes the next
	always_ff @(posedge clk) begin
		if (load) begin
			work_q  <= fq_data.payload;
			flags_q <= fq_data.flags;
		end else if (emit) begin
			work_q <= work_q >> CH_W;
		end
		if (emit) begin
			index_q <= chan_q;
			value_q <= value_next;
			lost_q  <= flags_q[FLAG_LOST_BIT];
			fs_q    <= flags_q[FLAG_FS_BIT];
			last_q  <= chan_last;
		end
	end

	assign empty         = !out_valid_q;
	assign channel_index = index_q;
	assign channel_value = value_q;
	assign frame_lost    = lost_q;
	assign failsafe      = fs_q;
	assign last          = last_q;

endmodule

// ----- rtl/sbus_frame_receiver_decoder_unit.sv -----
// top level of the sbus frame receiver decoder unit
//
// bytes from the uart enter on rx_byte with push; a transfer happens when push
// is high and full is low. full rises only on the closing byte of a frame
// while both frame queue slots are occupied, so every other byte is taken at
// once, one per cycle. bytes are dropped until start_byte is seen, then 25
// bytes form a frame. a frame whose last byte passes the end check yields
// 18 results, channel 0 first and channel 17 marked by last; a failed end
// check drops the frame without any result.
// results come out like a queue: while empty is low the oldest one is on the
// ports and pop takes it. after the closing byte the frame passes through the
// frame queue and the unpacker into the output register; the unpacker, a shift
// register moving one channel per cycle, then gives one result per cycle while
// pop keeps up. a stalled pop holds the output register; the frame queue lets
// two more frames land before the byte side is held off.
// the four configuration registers sit on the apb port at 0x0, 0x4, 0x8 and
// 0xc; the user must write them only while the block is idle, which the block
// itself does not enforce. reset restores their default values, returns to
// the start byte search and empties the frame queue and the output; no clearing pass is needed.
`include "sbus_frame_receiver_decoder_unit_defines.svh"

module sbus_frame_receiver_decoder_unit
	import sfrd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic [BYTE_W-1:0]  rx_byte,
	input  logic               pop,
	output logic               empty,
	output logic [IDX_W-1:0]   channel_index,
	output logic [CH_W-1:0]    channel_value,
	output logic               frame_lost,
	output logic               failsafe,
	output logic               last
);

	cfg_t   cfg;
	logic   fq_full;
	logic   fq_push;
	frame_t fq_wdata;
	logic   fq_pop;
	logic   fq_valid;
	frame_t fq_rdata;

	sfrd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfrd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.push    (push),
		.rx_byte (rx_byte),
		.full    (full),
		.fq_full (fq_full),
		.fq_push (fq_push),
		.fq_data (fq_wdata)
	);

	sfrd_frame_q u_frame_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fq_push),
		.push_data (fq_wdata),
		.full      (fq_full),
		.pop       (fq_pop),
		.valid     (fq_valid),
		.pop_data  (fq_rdata)
	);

	sfrd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fq_valid      (fq_valid),
		.fq_data       (fq_rdata),
		.fq_pop        (fq_pop),
		.pop           (pop),
		.empty         (empty),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.frame_lost    (frame_lost),
		.failsafe      (failsafe),
		.last          (last)
	);

	// byte side is only held off for want of a queue slot
	`SFRD_ASSERT(a_full_needs_queue_full, full |-> fq_full)
	// within a frame the next channel follows straight after a transfer
	`SFRD_ASSERT_NEXT(a_channel_sequence, (!empty && pop && !last), (!empty && channel_index == ($past(channel_index) + IDX_W'(1))))
	// last is set exactly on the final digital channel
	`SFRD_ASSERT(a_last_on_final, (!empty) |-> (last == (channel_index == CH_DIG1)))

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the sbus frame receiver decoder unit
module testbench
	import sfrd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES    = 10;
	localparam int CHANS_PER_FRAME = PROP_CHANNELS + 2;
	localparam int FLAG_POS        = FRAME_BYTES - 2;
	localparam int END_POS         = FRAME_BYTES - 1;
	localparam int PHASE_ITEMS     = 48;
	localparam int SETTLE_CYCLES   = 30;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int MAX_REPORTS     = 10;
	localparam int SIDE_RX         = 0;
	localparam int SIDE_OUT        = 1;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [CH_W-1:0]  value;
		logic             lost;
		logic             fs;
		logic             last;
	} chan_t;

	// one row of directed bytes; typed rows carry the expected channel set
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [4:0]        reps;
		logic              typed;
		logic [CH_W-1:0]   value;
		logic              lost;
		logic              fs;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               push = 1'b0;
	logic               full;
	logic [BYTE_W-1:0]  rx_byte = '0;
	logic               pop = 1'b0;
	logic               empty;
	logic [IDX_W-1:0]   channel_index;
	logic [CH_W-1:0]    channel_value;
	logic               frame_lost;
	logic               failsafe;
	logic               last;

	// decoder state as the block should hold it
	cfg_t              cfg_now;
	bit                synced;
	int                frame_fill;
	logic [BYTE_W-1:0] frame_bytes [FRAME_BYTES];
	chan_t             chan_expect_q [$];

	int mismatch_cnt = 0;
	int idle_cycles = 0;
	int wait_left [2] = '{0, 0};
	bit wait_calm [2];

	stim_row_t dir_tab [7] = '{
		'{8'h00, 5'd1, 1'b0, 11'd0, 1'b0, 1'b0},     // dropped, not in sync
		'{8'hFF, 5'd1, 1'b0, 11'd0, 1'b0, 1'b0},
		'{8'h0E, 5'd1, 1'b0, 11'd0, 1'b0, 1'b0},     // one off the start byte
		'{8'h0F, 5'd1, 1'b0, 11'd0, 1'b0, 1'b0},     // default start byte
		'{8'hFF, 5'd22, 1'b0, 11'd0, 1'b0, 1'b0},    // payload all ones
		'{8'h0F, 5'd1, 1'b0, 11'd0, 1'b0, 1'b0},     // both digitals, lost, failsafe
		'{8'h00, 5'd1, 1'b1, CH_MASK, 1'b1, 1'b1}    // plain end byte
	};

	sbus_frame_receiver_decoder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.push          (push),
		.full          (full),
		.rx_byte       (rx_byte),
		.pop           (pop),
		.empty         (empty),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.frame_lost    (frame_lost),
		.failsafe      (failsafe),
		.last          (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void flag_error(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS) begin
			$display("%s", msg);
		end
	endfunction

	// stretches of items either with no waiting at all or with random waits
	function automatic int draw_wait(input int side);
		if (wait_left[side] == 0) begin
			wait_left[side] = $urandom_range(10, 40);
			wait_calm[side] = ($urandom_range(0, 3) == 0);
		end
		wait_left[side]--;
		return wait_calm[side] ? 0 : $urandom_range(0, 10);
	endfunction

	// returns 1 when this byte closes a frame that passes the end check
	function automatic bit frame_accept_byte(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] endb;
		if (!synced && b != cfg_now.start_byte) begin
			return 1'b0;
		end
		synced = 1'b1;
		frame_bytes[frame_fill] = b;
		frame_fill++;
		if (frame_fill < FRAME_BYTES) begin
			return 1'b0;
		end
		synced = 1'b0;
		frame_fill = 0;
		endb = frame_bytes[END_POS];
		return (endb == cfg_now.end_byte) ||
			((endb & cfg_now.alt_end_mask) == cfg_now.alt_end_value);
	endfunction

	function automatic chan_t channel_of_frame(input int k);
		logic [PAYLOAD_W-1:0] payload;
		logic [BYTE_W-1:0]    flags;
		chan_t                r;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			payload[BYTE_W*i +: BYTE_W] = frame_bytes[i + 1];
		end
		flags = frame_bytes[FLAG_POS];
		r.idx = IDX_W'(k);
		if (k < PROP_CHANNELS) begin
			r.value = payload[CH_W*k +: CH_W];
		end else begin
			r.value = flags[k - PROP_CHANNELS] ? CH_MASK : '0;
		end
		r.lost = flags[FLAG_LOST_BIT];
		r.fs = flags[FLAG_FS_BIT];
		r.last = (IDX_W'(k) == CH_DIG1);
		return r;
	endfunction

	task automatic send_rx(input logic [BYTE_W-1:0] b, input logic typed,
			input logic [CH_W-1:0] tval, input logic tlost, input logic tfs);
		int    gap;
		int    k;
		chan_t r;
		gap = draw_wait(SIDE_RX);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		if (frame_accept_byte(b)) begin
			for (k = 0; k < CHANS_PER_FRAME; k++) begin
				r = channel_of_frame(k);
				if (typed) begin
					r.value = tval;
					r.lost = tlost;
					r.fs = tfs;
				end
				chan_expect_q.push_back(r);
			end
		end
	endtask

	// whole or cut-short frame from the current start byte
	task automatic send_frame(input int nbytes);
		logic [BYTE_W-1:0] b;
		int                fill;
		int                ending;
		int                n;
		fill = $urandom_range(0, 3);
		ending = $urandom_range(0, 2);
		for (n = 0; n < nbytes; n++) begin
			if (n == 0) begin
				b = cfg_now.start_byte;
			end else if (n <= PAYLOAD_BYTES) begin
				case (fill)
					0: b = 8'($urandom_range(0, 255));
					1: b = 8'h00;
					2: b = 8'hFF;
					default: begin
						// start byte inside the payload must pass as data
						b = ($urandom_range(0, 3) == 0) ? cfg_now.start_byte
							: 8'($urandom_range(0, 255));
					end
				endcase
			end else if (n == FLAG_POS) begin
				b = 8'($urandom_range(0, 255));
			end else begin
				case (ending)
					0: b = cfg_now.end_byte;
					1: begin
						b = (8'($urandom_range(0, 255)) & ~cfg_now.alt_end_mask) |
							(cfg_now.alt_end_value & cfg_now.alt_end_mask);
					end
					default: b = 8'($urandom_range(0, 255));
				endcase
			end
			send_rx(b, 1'b0, '0, 1'b0, 1'b0);
		end
	endtask

	task automatic random_phase();
		int sent;
		int n;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(1, 4)) begin
						send_rx(8'($urandom_range(0, 255)), 1'b0, '0, 1'b0, 1'b0);
					end
				end
				1: begin
					n = $urandom_range(1, FRAME_BYTES - 1);
					send_frame(n);
					sent += n;
				end
				default: begin
					send_frame(FRAME_BYTES);
					sent += FRAME_BYTES;
				end
			endcase
		end
	endtask

	// all results in, then time for a frame that ends without any
	task automatic settle();
		push <= 1'b0;
		while (chan_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [BYTE_W-1:0] v);
		logic [PDATA_W-1:0] data;
		data = $urandom();
		data[BYTE_W-1:0] = v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx));
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_START_BYTE:    cfg_now.start_byte = v;
			REG_END_BYTE:      cfg_now.end_byte = v;
			REG_ALT_END_MASK:  cfg_now.alt_end_mask = v;
			REG_ALT_END_VALUE: cfg_now.alt_end_value = v;
			default: ;
		endcase
		// read back in the next transfer
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[BYTE_W-1:0] !== v) begin
			flag_error($sformatf("register %s read back: expected %02h, got %02h",
				idx.name(), v, prdata[BYTE_W-1:0]));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [BYTE_W-1:0] vals [4];
		logic [BYTE_W-1:0] phase_cfg [4][4];
		stim_row_t         row;
		phase_cfg[0] = '{8'hFF, 8'hFF, 8'h00, 8'h00};
		phase_cfg[1] = '{8'h00, 8'h00, 8'hFF, 8'hFF};
		phase_cfg[2] = '{8'h5A, 8'hA5, 8'h3C, 8'h14};
		phase_cfg[3] = '{8'h0F, 8'h00, 8'h0F, 8'h04};
		cfg_now = '{start_byte: 8'h0F, end_byte: 8'h00, alt_end_mask: 8'h0F,
			alt_end_value: 8'h04};
		synced = 1'b0;
		frame_fill = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 7; i++) begin
			row = dir_tab[i];
			for (int j = 0; j < int'(row.reps); j++) begin
				send_rx(row.data, row.typed && (j == int'(row.reps) - 1),
					row.value, row.lost, row.fs);
			end
		end
		random_phase();

		// extremes first, then a random setting, then the defaults again
		for (int p = 0; p < 4; p++) begin
			settle();
			vals = phase_cfg[p];
			if (p == 2) begin
				for (int i = 0; i < 4; i++) begin
					vals[i] = 8'($urandom_range(0, 255));
				end
			end
			for (int i = 0; i < 4; i++) begin
				write_reg(reg_idx_t'(i), vals[i]);
			end
			random_phase();
		end
		settle();

		if (mismatch_cnt == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	// result side: a random stall, or none in calm stretches, before each transfer
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = draw_wait(SIDE_OUT);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	always @(posedge clk) begin
		chan_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (chan_expect_q.size() == 0) begin
					flag_error($sformatf("unexpected result: ch %0d val %0d lost %0b fs %0b last %0b",
						channel_index, channel_value, frame_lost, failsafe, last));
				end else begin
					want = chan_expect_q.pop_front();
					if (channel_index !== want.idx || channel_value !== want.value ||
							frame_lost !== want.lost || failsafe !== want.fs ||
							last !== want.last) begin
						flag_error({
							$sformatf("result mismatch: expected ch %0d val %0d ",
								want.idx, want.value),
							$sformatf("lost %0b fs %0b last %0b, ",
								want.lost, want.fs, want.last),
							$sformatf("got ch %0d val %0d lost %0b fs %0b last %0b",
								channel_index, channel_value, frame_lost, failsafe,
								last)});
					end
				end
			end
			if ((push && !full) || (pop && !empty) || (psel && penable)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sfrd_pkg.sv
rtl/sfrd_regs.sv
rtl/sfrd_front.sv
rtl/sfrd_frame_q.sv
rtl/sfrd_back.sv
rtl/sbus_frame_receiver_decoder_unit.sv
tb/testbench.sv
